@@ rtl/core/ieq_pkg.sv @@
// Shared types, constants and codes of the input event queue.
package ieq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int TAG_BITS = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [31:0] STALE_RESET = 32'd100000;
	localparam logic [6:0] CAP_RESET = 7'd64;
	localparam logic [6:0] RESERVE_RESET = 7'd8;

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_TAKE = 2'd1,
		OP_REPORT = 2'd2,
		OP_NONE = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		KIND_MOTION = 3'd0,
		KIND_WHEEL = 3'd1,
		KIND_REPEAT = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_OTHER = 3'd4
	} kind_e;

	typedef enum logic [3:0] {
		ST_ACCEPTED = 4'd0,
		ST_EVICTED = 4'd1,
		ST_COALESCED = 4'd2,
		ST_FULL = 4'd3,
		ST_FAILED = 4'd4,
		ST_EMPTY = 4'd5,
		ST_DELIVER = 4'd6,
		ST_STALE = 4'd7,
		ST_OK = 4'd8,
		ST_FAIL = 4'd9,
		ST_NOTHING = 4'd10,
		ST_BUSY = 4'd11
	} status_e;

	typedef enum logic [1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_RESERVE = 2'd1,
		CFG_STALE = 2'd2
	} cfg_idx_e;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TAIL_CHK,
		S_LIMIT,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_SH_START,
		S_SH_RUN,
		S_APPEND,
		S_TAKE_CHK,
		S_REPORT,
		S_FINISH
	} state_e;

	typedef struct packed {
		logic [2:0] kind;
		logic stream;
		logic [TAG_BITS-1:0] tag;
		logic [31:0] src_time;
	} entry_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] item_kind;
		logic stream_id;
		logic has_key_release;
		logic has_events;
		logic [15:0] payload_tag;
		logic [31:0] source_time_us;
		logic [31:0] now_us;
		logic delivery_ok;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] status;
		logic [2:0] out_kind;
		logic out_stream;
		logic [15:0] out_payload_tag;
		logic [31:0] out_source_time_us;
		logic [6:0] depth_after;
		logic [31:0] dropped_count;
		logic [31:0] coalesced_count;
		logic [31:0] delivered_count;
		logic [31:0] submitted_count;
		logic [6:0] max_depth_seen;
		logic [31:0] peak_latency_us;
	} out_beat_t;

	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t wr_data;
	} mem_ctl_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

@@ rtl/core/input_event_queue_with_coalescing_core.sv @@
// Top level of the input event queue: sequencer, queue state, statistics and beat registers.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data (in_beat_t)
//   out     | output    | out_valid / out_ready| out_data (out_beat_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One beat is accepted only while the sequencer is idle. A submit that must evict walks the
// entry store through its single read port, one entry at a time, and then closes the gap with
// one copy per cycle. Reset clears all control state and the statistics; the entry store holds
// no reset value. A stalled result beat holds the sequencer in its final state until the beat
// is taken.
module input_event_queue_with_coalescing_core import ieq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_wdata
);
	state_e state_q, state_d;

	// Configuration registers.
	logic [6:0] cap_q, reserve_q;
	logic [31:0] stale_q;

	// Queue control: the store is a ring addressed from the head.
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic pending_q, failed_q;
	logic [31:0] pend_time_q;

	// Statistics.
	logic [31:0] submitted_q, delivered_q, dropped_q, coalesced_q, lat_peak_q;
	logic [CNT_W-1:0] depth_peak_q;

	// Captured input beat and the result under construction.
	in_beat_t req_q;
	entry_t item_q;
	status_e status_q;
	entry_t taken_q;
	logic have_q;
	logic out_valid_q;
	out_beat_t out_q;

	mem_ctl_t mem_ctl;
	entry_t rd_data;

	logic [31:0] alu_a, alu_b, alu_bound, alu_diff;
	logic alu_above;

	ieq_mem u_mem (.clk(clk), .ctl(mem_ctl), .rd_data(rd_data));

	ieq_alu u_alu (
		.a(alu_a), .b(alu_b), .bound(alu_bound), .diff(alu_diff), .above(alu_above)
	);

	// Effective limits derived from the configuration.
	logic [CNT_W-1:0] cap_eff, res_eff, limit;
	logic rel_item;
	always_comb begin
		if (cap_q == 7'd0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > QUEUE_DEPTH) begin
			cap_eff = CNT_W'(QUEUE_DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
		res_eff = (CNT_W'(reserve_q) < cap_eff && 32'(reserve_q) <= QUEUE_DEPTH) ?
			CNT_W'(reserve_q) : cap_eff;
		rel_item = (item_q.kind == KIND_RELEASE) || req_q.has_key_release;
		limit = rel_item ? cap_eff : cap_eff - res_eff;
	end

	logic [IDX_W-1:0] tail_addr, idx_addr, idx_next_addr, append_addr;
	logic kind_evictable;
	logic [CNT_W:0] idx_p1, idx_p2;
	assign tail_addr = head_q + IDX_W'(count_q - CNT_W'(1));
	assign idx_addr = head_q + idx_q[IDX_W-1:0];
	assign idx_next_addr = head_q + IDX_W'(idx_q + CNT_W'(1));
	assign append_addr = head_q + count_q[IDX_W-1:0];
	assign idx_p1 = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (CNT_W+1)'(2);
	assign kind_evictable = (rd_data.kind == KIND_MOTION) || (rd_data.kind == KIND_REPEAT);

	// The time unit compares a taken entry's age against the stale limit, and a
	// reported latency against the running peak.
	always_comb begin
		alu_a = req_q.now_us;
		if (state_q == S_REPORT) begin
			alu_b = pend_time_q;
			alu_bound = lat_peak_q;
		end else begin
			alu_b = rd_data.src_time;
			alu_bound = stale_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (req_q.operation)
					OP_SUBMIT: begin
						if (!req_q.has_events || failed_q) begin
							state_d = S_FINISH;
						end else if (item_q.kind == KIND_MOTION && count_q != '0) begin
							state_d = S_TAIL_CHK;
						end else begin
							state_d = S_LIMIT;
						end
					end
					OP_TAKE: begin
						state_d = (pending_q || count_q == '0) ? S_FINISH : S_TAKE_CHK;
					end
					OP_REPORT: state_d = pending_q ? S_REPORT : S_FINISH;
					default: state_d = S_FINISH;
				endcase
			end
			S_TAIL_CHK: begin
				state_d = (rd_data.kind == KIND_MOTION && rd_data.stream == item_q.stream) ?
					S_FINISH : S_LIMIT;
			end
			S_LIMIT: state_d = (count_q >= limit) ? S_SRCH_RD : S_APPEND;
			S_SRCH_RD: state_d = (idx_q < count_q) ? S_SRCH_CHK : S_FINISH;
			S_SRCH_CHK: begin
				if (!kind_evictable) begin
					state_d = S_SRCH_RD;
				end else if (idx_q == '0) begin
					state_d = S_APPEND;
				end else begin
					state_d = S_SH_START;
				end
			end
			S_SH_START: state_d = (idx_p1 < {1'b0, count_q}) ? S_SH_RUN : S_APPEND;
			S_SH_RUN: state_d = (idx_p2 < {1'b0, count_q}) ? S_SH_RUN : S_APPEND;
			S_APPEND: state_d = S_FINISH;
			S_TAKE_CHK: state_d = S_FINISH;
			S_REPORT: state_d = S_FINISH;
			S_FINISH: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Store port controls.
	always_comb begin
		mem_ctl = '0;
		unique case (state_q)
			S_DECODE: begin
				mem_ctl.rd_en = 1'b1;
				mem_ctl.rd_addr = (req_q.operation == OP_TAKE) ? head_q : tail_addr;
			end
			S_TAIL_CHK: begin
				if (rd_data.kind == KIND_MOTION && rd_data.stream == item_q.stream) begin
					mem_ctl.wr_en = 1'b1;
					mem_ctl.wr_addr = tail_addr;
					mem_ctl.wr_data = item_q;
				end
			end
			S_SRCH_RD: begin
				mem_ctl.rd_en = idx_q < count_q;
				mem_ctl.rd_addr = idx_addr;
			end
			S_SH_START: begin
				mem_ctl.rd_en = 1'b1;
				mem_ctl.rd_addr = idx_next_addr;
			end
			S_SH_RUN: begin
				mem_ctl.wr_en = 1'b1;
				mem_ctl.wr_addr = idx_addr;
				mem_ctl.wr_data = rd_data;
				mem_ctl.rd_en = 1'b1;
				mem_ctl.rd_addr = head_q + IDX_W'(idx_p2);
			end
			S_APPEND: begin
				mem_ctl.wr_en = count_q < CNT_W'(QUEUE_DEPTH);
				mem_ctl.wr_addr = append_addr;
				mem_ctl.wr_data = item_q;
			end
			default: mem_ctl = '0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			reserve_q <= RESERVE_RESET;
			stale_q <= STALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY: cap_q <= cfg_wdata[6:0];
				CFG_RESERVE: reserve_q <= cfg_wdata[6:0];
				CFG_STALE: stale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer datapath.
	logic [32:0] drop_sum;
	assign drop_sum = {1'b0, dropped_q} + 33'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			pending_q <= 1'b0;
			failed_q <= 1'b0;
			pend_time_q <= '0;
			submitted_q <= '0;
			delivered_q <= '0;
			dropped_q <= '0;
			coalesced_q <= '0;
			lat_peak_q <= '0;
			depth_peak_q <= '0;
			status_q <= ST_NOTHING;
			have_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// The result beat is raised when the final state may load it, and dropped
			// once the receiver has taken it.
			if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					have_q <= 1'b0;
					status_q <= ST_NOTHING;
					idx_q <= '0;
				end
				S_DECODE: begin
					unique case (req_q.operation)
						OP_SUBMIT: begin
							if (!req_q.has_events) begin
								status_q <= ST_ACCEPTED;
							end else if (failed_q) begin
								status_q <= ST_FAILED;
							end else begin
								submitted_q <= sat_inc(submitted_q);
								status_q <= ST_ACCEPTED;
							end
						end
						OP_TAKE: begin
							if (pending_q) begin
								status_q <= ST_BUSY;
							end else if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end
						end
						default: status_q <= ST_NOTHING;
					endcase
				end
				S_TAIL_CHK: begin
					if (rd_data.kind == KIND_MOTION && rd_data.stream == item_q.stream) begin
						coalesced_q <= sat_inc(coalesced_q);
						status_q <= ST_COALESCED;
					end
				end
				S_LIMIT: begin
					if (count_q >= limit) begin
						dropped_q <= sat_inc(dropped_q);
					end
				end
				S_SRCH_RD: begin
					if (idx_q >= count_q) begin
						status_q <= ST_FULL;
					end
				end
				S_SRCH_CHK: begin
					if (kind_evictable) begin
						status_q <= ST_EVICTED;
						if (idx_q == '0) begin
							head_q <= head_q + IDX_W'(1);
							count_q <= count_q - CNT_W'(1);
						end
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_SH_START: begin
					if (!(idx_p1 < {1'b0, count_q})) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_SH_RUN: begin
					idx_q <= idx_q + CNT_W'(1);
					if (!(idx_p2 < {1'b0, count_q})) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_APPEND: begin
					if (count_q < CNT_W'(QUEUE_DEPTH)) begin
						count_q <= count_q + CNT_W'(1);
						if (count_q + CNT_W'(1) > depth_peak_q) begin
							depth_peak_q <= count_q + CNT_W'(1);
						end
					end else if (count_q > depth_peak_q) begin
						depth_peak_q <= count_q;
					end
				end
				S_TAKE_CHK: begin
					taken_q <= rd_data;
					have_q <= 1'b1;
					head_q <= head_q + IDX_W'(1);
					count_q <= count_q - CNT_W'(1);
					if (alu_above && rd_data.kind <= KIND_REPEAT) begin
						dropped_q <= sat_inc(dropped_q);
						status_q <= ST_STALE;
					end else begin
						pending_q <= 1'b1;
						pend_time_q <= rd_data.src_time;
						status_q <= ST_DELIVER;
					end
				end
				S_REPORT: begin
					pending_q <= 1'b0;
					if (req_q.delivery_ok) begin
						delivered_q <= sat_inc(delivered_q);
						if (alu_above) begin
							lat_peak_q <= alu_diff;
						end
						status_q <= ST_OK;
					end else begin
						failed_q <= 1'b1;
						dropped_q <= drop_sum[32] ? '1 : drop_sum[31:0];
						count_q <= '0;
						status_q <= ST_FAIL;
					end
				end
				default: ;
			endcase
		end
	end

	// Captured beat, the item built from it, and the result beat register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
			item_q.kind <= (in_data.item_kind > KIND_OTHER) ? KIND_OTHER : in_data.item_kind;
			item_q.stream <= in_data.stream_id;
			item_q.tag <= in_data.payload_tag[TAG_BITS-1:0];
			item_q.src_time <= (in_data.source_time_us == '0) ?
				in_data.now_us : in_data.source_time_us;
		end
		if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
			out_q.status <= status_q;
			out_q.out_kind <= have_q ? taken_q.kind : '0;
			out_q.out_stream <= have_q ? taken_q.stream : 1'b0;
			out_q.out_payload_tag <= have_q ? 16'(taken_q.tag) : '0;
			out_q.out_source_time_us <= have_q ? taken_q.src_time : '0;
			out_q.depth_after <= 7'(count_q);
			out_q.dropped_count <= dropped_q;
			out_q.coalesced_count <= coalesced_q;
			out_q.delivered_count <= delivered_q;
			out_q.submitted_count <= submitted_q;
			out_q.max_depth_seen <= 7'(depth_peak_q);
			out_q.peak_latency_us <= lat_peak_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The queue never holds more entries than the store has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond store depth");

	// A transport failure stays latched.
	assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("transport failure flag cleared");

	// The store is never written while the sequencer waits for a beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_ctl.wr_en)
		else $error("store written while idle");

	// A take that hands out an entry leaves a delivery pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && status_q == ST_DELIVER) |-> pending_q)
		else $error("delivery without pending report");
endmodule

@@ rtl/core/ieq_mem.sv @@
// Entry store of the queue: one write port and one registered read port.
module ieq_mem import ieq_pkg::*; (
	input logic clk,
	input mem_ctl_t ctl,
	output entry_t rd_data
);
	entry_t mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[ctl.rd_addr];
		end
	end
endmodule

@@ rtl/core/ieq_alu.sv @@
// Shared time unit: modular difference of two times and compare against a bound.
module ieq_alu import ieq_pkg::*; (
	input logic [31:0] a,
	input logic [31:0] b,
	input logic [31:0] bound,
	output logic [31:0] diff,
	output logic above
);
	assign diff = a - b;
	assign above = diff > bound;
endmodule
